[rtl/bfifo_pkg.sv]
package bfifo_pkg;

   // ring geometry
   localparam int DEPTH      = 1024;
   localparam int LANES      = 8;
   localparam int LANE_W     = $clog2(LANES);
   localparam int PTR_W      = $clog2(DEPTH);
   localparam int CNT_W      = PTR_W + 1;
   localparam int ROW_W      = PTR_W - LANE_W;
   localparam int BANK_DEPTH = DEPTH / LANES;

   // transaction field widths
   localparam int LEN_W  = 4;
   localparam int DATA_W = 64;
   localparam int FILL_W = 11;

   // operation codes
   localparam logic OP_PUT = 1'b0;
   localparam logic OP_GET = 1'b1;

   typedef struct packed {
      logic             wr_en;
      logic             rd_en;
      logic [ROW_W-1:0] row;
      logic [7:0]       wdata;
   } lane_cmd_type;

   typedef struct packed {
      logic [LANE_W-1:0] start;
      logic [LEN_W-1:0]  count;
   } merge_ctl_type;

endpackage

[rtl/bfifo_if.sv]
interface bfifo_req_if;
   logic                         valid;
   logic                         ready;
   logic                         operation;
   logic [bfifo_pkg::DATA_W-1:0] data_in;
   logic [bfifo_pkg::LEN_W-1:0]  request_length;
   logic                         all_or_nothing;

   modport source (output valid, operation, data_in, request_length, all_or_nothing,
                   input ready);
   modport sink   (input valid, operation, data_in, request_length, all_or_nothing,
                   output ready);
endinterface

interface bfifo_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [bfifo_pkg::LEN_W-1:0]  moved_count;
   logic [bfifo_pkg::DATA_W-1:0] data_out;
   logic [bfifo_pkg::FILL_W-1:0] fill_level;

   modport source (output valid, moved_count, data_out, fill_level, input ready);
   modport sink   (input valid, moved_count, data_out, fill_level, output ready);
endinterface

[rtl/bfifo_lane.sv]
// one byte bank of the ring: holds every LANES-th byte
module bfifo_lane (
   input  logic                    clock,
   input  bfifo_pkg::lane_cmd_type cmd,
   output logic [7:0]              rdata
);

   logic [7:0] bank_mem [bfifo_pkg::BANK_DEPTH];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         bank_mem[cmd.row] <= cmd.wdata;
      end
      if (cmd.rd_en) begin
         rdata_ff <= bank_mem[cmd.row];
      end
   end

   assign rdata = rdata_ff;

endmodule

[rtl/bfifo_merge.sv]
// rotate lane bytes back into ring order, zero the unused ones
module bfifo_merge (
   input  logic [bfifo_pkg::LANES-1:0][7:0] lane_data,
   input  bfifo_pkg::merge_ctl_type         ctl,
   output logic [bfifo_pkg::DATA_W-1:0]     data_out
);

   localparam int Lanes = bfifo_pkg::LANES;
   localparam int LaneW = bfifo_pkg::LANE_W;
   localparam int LenW  = bfifo_pkg::LEN_W;

   logic [Lanes-1:0][7:0] out_bytes;

   always_comb begin
      for (int k = 0; k < Lanes; k++) begin
         if (LenW'(k) < ctl.count) begin
            out_bytes[k] = lane_data[LaneW'(ctl.start + LaneW'(k))];
         end else begin
            out_bytes[k] = 8'h00;
         end
      end
   end

   assign data_out = out_bytes;

endmodule

[rtl/byte_ring_fifo_burst.sv]
// Byte FIFO on a power-of-two ring, moved in bursts of up to eight bytes.
// req_chan carries one transaction per put (operation 0) or get (operation 1)
// of request_length bytes; lengths above eight count as eight. A put stores
// as many bytes as there is room for, a get returns as many as are held,
// oldest in bits 7:0 and unused bytes zero. With all_or_nothing set, a
// transaction that cannot be met whole moves nothing.
// rsp_chan returns exactly one transaction per request: moved_count,
// data_out and fill_level after the request, in request order.
// The store is split over eight byte banks, one per lane, so that any burst
// of consecutive bytes touches each bank at most once.
// The bank read is registered in the lanes at the accepting edge, the merge
// is registered in the output register when the bank stage advances, and
// the response is held there until rsp_chan takes it.
// Throughput: one transaction per cycle while rsp_chan does not stall, set by the
// single read/write port of each bank; a get may follow a put on the next cycle.
// Reset clears both ring counters and empties the pipeline; bank contents
// are left as they are. When rsp_chan stalls, one transaction waits in the
// output register and one more in the bank stage, then req_chan.ready drops.
module byte_ring_fifo_burst (
   input logic         clock,
   input logic         reset,
   bfifo_req_if.sink   req_chan,
   bfifo_rsp_if.source rsp_chan
);

   localparam int Depth = bfifo_pkg::DEPTH;
   localparam int Lanes = bfifo_pkg::LANES;
   localparam int LaneW = bfifo_pkg::LANE_W;
   localparam int PtrW  = bfifo_pkg::PTR_W;
   localparam int CntW  = bfifo_pkg::CNT_W;
   localparam int LenW  = bfifo_pkg::LEN_W;
   localparam int DataW = bfifo_pkg::DATA_W;
   localparam int FillW = bfifo_pkg::FILL_W;

   // ring counters, free running modulo 2*Depth
   logic [CntW-1:0] wr_cnt_ff, wr_cnt_in;
   logic [CntW-1:0] rd_cnt_ff, rd_cnt_in;

   // bank stage
   logic                      s1_valid_ff, s1_valid_in;
   bfifo_pkg::merge_ctl_type  s1_ctl_ff;
   logic [LenW-1:0]           s1_moved_ff;
   logic [CntW-1:0]           s1_level_ff;

   // output register
   logic             out_valid_ff, out_valid_in;
   logic [LenW-1:0]  out_moved_ff;
   logic [DataW-1:0] out_data_ff;
   logic [CntW-1:0]  out_level_ff;

   // request decode
   logic                  accept;
   logic                  is_get;
   logic [LenW-1:0]       want;
   logic [CntW-1:0]       level_raw;
   logic [CntW-1:0]       level;
   logic [CntW-1:0]       avail;
   logic [LenW-1:0]       n_moved;
   logic [PtrW-1:0]       base;
   logic [LaneW-1:0]      start;
   logic [Lanes-1:0][7:0] in_bytes;

   logic                  out_free;
   logic                  s1_adv;

   bfifo_pkg::lane_cmd_type     lane_cmd [Lanes];
   logic [Lanes-1:0][7:0]       lane_data;
   logic [DataW-1:0]            merged;

   // handshake: bank stage moves on when the output register is free
   assign out_free       = !out_valid_ff || rsp_chan.ready;
   assign s1_adv         = s1_valid_ff && out_free;
   assign req_chan.ready = !s1_valid_ff || out_free;
   assign accept         = req_chan.valid && req_chan.ready;

   assign is_get   = (req_chan.operation == bfifo_pkg::OP_GET);
   assign in_bytes = req_chan.data_in;

   always_comb begin
      if (req_chan.request_length > LenW'(Lanes)) begin
         want = LenW'(Lanes);
      end else begin
         want = req_chan.request_length;
      end

      level_raw = CntW'(wr_cnt_ff - rd_cnt_ff);
      if (level_raw > CntW'(Depth)) begin
         level = CntW'(Depth);
      end else begin
         level = level_raw;
      end

      if (is_get) begin
         avail = level;
      end else begin
         avail = CntW'(CntW'(Depth) - level);
      end

      // short of room or bytes: all-or-nothing moves none, else take what fits
      if (avail < CntW'(want)) begin
         if (req_chan.all_or_nothing) begin
            n_moved = '0;
         end else begin
            n_moved = LenW'(avail);
         end
      end else begin
         n_moved = want;
      end

      base  = is_get ? rd_cnt_ff[PtrW-1:0] : wr_cnt_ff[PtrW-1:0];
      start = base[LaneW-1:0];
   end

   // each lane picks the burst byte that lands in its bank
   always_comb begin
      logic [LaneW-1:0] k;
      logic [PtrW-1:0]  addr;
      logic             active;
      for (int b = 0; b < Lanes; b++) begin
         k      = LaneW'(LaneW'(b) - start);
         addr   = PtrW'(base + PtrW'(k));
         active = (LenW'(k) < n_moved);
         lane_cmd[b].wr_en = accept && !is_get && active;
         lane_cmd[b].rd_en = accept && is_get && active;
         lane_cmd[b].row   = addr[PtrW-1:LaneW];
         lane_cmd[b].wdata = in_bytes[k];
      end
   end

   for (genvar g = 0; g < Lanes; g++) begin : g_lane
      bfifo_lane u_lane (
         .clock (clock),
         .cmd   (lane_cmd[g]),
         .rdata (lane_data[g])
      );
   end

   bfifo_merge u_merge (
      .lane_data (lane_data),
      .ctl       (s1_ctl_ff),
      .data_out  (merged)
   );

   // counter and valid next values
   always_comb begin
      wr_cnt_in = wr_cnt_ff;
      rd_cnt_in = rd_cnt_ff;
      if (accept) begin
         if (is_get) begin
            rd_cnt_in = CntW'(rd_cnt_ff + CntW'(n_moved));
         end else begin
            wr_cnt_in = CntW'(wr_cnt_ff + CntW'(n_moved));
         end
      end

      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      if (s1_adv) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_cnt_ff    <= '0;
         rd_cnt_ff    <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         wr_cnt_ff    <= wr_cnt_in;
         rd_cnt_ff    <= rd_cnt_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ctl_ff.start <= start;
         s1_ctl_ff.count <= is_get ? n_moved : '0;
         s1_moved_ff     <= n_moved;
         s1_level_ff     <= CntW'(wr_cnt_in - rd_cnt_in);
      end
      if (s1_adv) begin
         out_moved_ff <= s1_moved_ff;
         out_data_ff  <= merged;
         out_level_ff <= s1_level_ff;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.moved_count = out_moved_ff;
   assign rsp_chan.data_out    = out_data_ff;
   assign rsp_chan.fill_level  = FillW'(out_level_ff);

`ifndef SYNTHESIS
   a_level_bound : assert property (@(posedge clock) disable iff (reset)
      level_raw <= CntW'(Depth))
      else $error("ring level beyond depth");

   a_count_step : assert property (@(posedge clock) disable iff (reset)
      accept |=> CntW'(wr_cnt_ff - $past(wr_cnt_ff) + rd_cnt_ff - $past(rd_cnt_ff))
                 == CntW'($past(n_moved)))
      else $error("counters did not advance by bytes moved");

   a_count_idle : assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(wr_cnt_ff) && $stable(rd_cnt_ff))
      else $error("counters moved without a transaction");

   a_zero_data : assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.moved_count == '0) |-> rsp_chan.data_out == '0)
      else $error("data on a transaction that moved nothing");
`endif

endmodule
